// File: hdl/cpf_pkg.sv
// Shared types and constants of the Coulomb pair force block.
// Holds the word layouts, the controller command set and the saturating adder.
// Depends on nothing.
`default_nettype none

package cpf_pkg;

	// Widest slot index that the parameter range needs.
	localparam int IDX_W = 6;

	// Action codes of an input word.
	localparam logic ACT_LOAD    = 1'b0;
	localparam logic ACT_COMPUTE = 1'b1;

	// Configuration register indexes.
	localparam logic REG_COULOMB_GAIN = 1'b0;
	localparam logic REG_DRAG_COEFF   = 1'b1;

	typedef struct packed {
		logic               action;
		logic [3:0]         body_index;
		logic               present;
		logic signed [31:0] position_x;
		logic signed [31:0] position_y;
		logic signed [15:0] charge;
		logic signed [31:0] speed_x;
		logic signed [31:0] speed_y;
	} item_t;

	typedef struct packed {
		logic [3:0]         slot;
		logic               occupied;
		logic signed [47:0] force_x;
		logic signed [47:0] force_y;
		logic               last;
	} result_t;

	// One stored body.
	typedef struct packed {
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [15:0] charge;
		logic [31:0] vel_x;
		logic [31:0] vel_y;
	} body_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_BEGIN,
		OP_SELF,
		OP_READ_PEER,
		OP_PEER,
		OP_SQX,
		OP_SQY,
		OP_SQRT,
		OP_DEN,
		OP_KQ,
		OP_NUMX,
		OP_DIVX,
		OP_ADDX,
		OP_NUMY,
		OP_DIVY,
		OP_ADDY,
		OP_DRGX,
		OP_DRGY,
		OP_DRGE,
		OP_EMIT
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [IDX_W-1:0] self_idx;
		logic [IDX_W-1:0] peer_idx;
	} cmd_t;

	typedef struct packed {
		logic busy;
		logic r2_zero;
		logic self_present;
		logic peer_present;
		logic out_full;
	} stat_t;

	// Adds a signed 50-bit term to a 48-bit accumulator and clamps the sum.
	function automatic logic [47:0] sat_add48(input logic [47:0] acc, input logic [49:0] term);
		logic [50:0] s;
		s = {{3{acc[47]}}, acc} + {term[49], term};
		if (s[50:47] == 4'b0000 || s[50:47] == 4'b1111) begin
			return s[47:0];
		end else if (s[50]) begin
			return 48'h8000_0000_0000;
		end else begin
			return 48'h7fff_ffff_ffff;
		end
	endfunction

endpackage

`default_nettype wire

// File: hdl/cpf_ctrl.sv
// Sequencing state machine of the Coulomb pair force block.
// Uses cpf_pkg for the command and status types; drives cpf_dp.
`default_nettype none

module cpf_ctrl #(
	parameter int MAX_BODIES = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	input  logic           item_action,
	output logic           item_ready,
	input  cpf_pkg::stat_t stat,
	output cpf_pkg::cmd_t  cmd
);

	localparam int IW = $clog2(MAX_BODIES);
	localparam logic [IW-1:0] LAST = IW'(MAX_BODIES - 1);

	typedef enum logic [20:0] {
		S_IDLE  = 21'h000001,
		S_BEGIN = 21'h000002,
		S_SELF  = 21'h000004,
		S_PICK  = 21'h000008,
		S_PEER  = 21'h000010,
		S_SQX   = 21'h000020,
		S_SQY   = 21'h000040,
		S_ZCHK  = 21'h000080,
		S_DEN   = 21'h000100,
		S_KQ    = 21'h000200,
		S_NUMX  = 21'h000400,
		S_DIVX  = 21'h000800,
		S_ADDX  = 21'h001000,
		S_NUMY  = 21'h002000,
		S_DIVY  = 21'h004000,
		S_ADDY  = 21'h008000,
		S_NEXT  = 21'h010000,
		S_DRG0  = 21'h020000,
		S_DRG1  = 21'h040000,
		S_DRG2  = 21'h080000,
		S_EMIT  = 21'h100000
	} state_t;

	state_t state_q, state_d;
	logic [IW-1:0] b_q, b_d, p_q, p_d;
	cpf_pkg::op_t op;

	assign item_ready = (state_q == S_IDLE);
	assign cmd.op = op;
	assign cmd.self_idx = cpf_pkg::IDX_W'(b_q);
	assign cmd.peer_idx = cpf_pkg::IDX_W'(p_q);

	always_comb begin
		state_d = state_q;
		b_d = b_q;
		p_d = p_q;
		op = cpf_pkg::OP_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					if (item_action == cpf_pkg::ACT_LOAD) begin
						op = cpf_pkg::OP_LOAD;
					end else begin
						b_d = '0;
						state_d = S_BEGIN;
					end
				end
			end
			S_BEGIN: begin
				op = cpf_pkg::OP_BEGIN;
				state_d = S_SELF;
			end
			S_SELF: begin
				op = cpf_pkg::OP_SELF;
				p_d = '0;
				state_d = stat.self_present ? S_PICK : S_EMIT;
			end
			S_PICK: begin
				if (p_q == b_q || !stat.peer_present) begin
					state_d = S_NEXT;
				end else begin
					op = cpf_pkg::OP_READ_PEER;
					state_d = S_PEER;
				end
			end
			S_PEER: begin
				op = cpf_pkg::OP_PEER;
				state_d = S_SQX;
			end
			S_SQX: begin
				op = cpf_pkg::OP_SQX;
				state_d = S_SQY;
			end
			S_SQY: begin
				if (!stat.busy) begin
					op = cpf_pkg::OP_SQY;
					state_d = S_ZCHK;
				end
			end
			S_ZCHK: begin
				if (!stat.busy) begin
					if (stat.r2_zero) begin
						state_d = S_NEXT;
					end else begin
						op = cpf_pkg::OP_SQRT;
						state_d = S_DEN;
					end
				end
			end
			S_DEN: begin
				if (!stat.busy) begin
					op = cpf_pkg::OP_DEN;
					state_d = S_KQ;
				end
			end
			S_KQ: begin
				if (!stat.busy) begin
					op = cpf_pkg::OP_KQ;
					state_d = S_NUMX;
				end
			end
			S_NUMX: begin
				op = cpf_pkg::OP_NUMX;
				state_d = S_DIVX;
			end
			S_DIVX: begin
				if (!stat.busy) begin
					op = cpf_pkg::OP_DIVX;
					state_d = S_ADDX;
				end
			end
			S_ADDX: begin
				if (!stat.busy) begin
					op = cpf_pkg::OP_ADDX;
					state_d = S_NUMY;
				end
			end
			S_NUMY: begin
				op = cpf_pkg::OP_NUMY;
				state_d = S_DIVY;
			end
			S_DIVY: begin
				if (!stat.busy) begin
					op = cpf_pkg::OP_DIVY;
					state_d = S_ADDY;
				end
			end
			S_ADDY: begin
				if (!stat.busy) begin
					op = cpf_pkg::OP_ADDY;
					state_d = S_NEXT;
				end
			end
			S_NEXT: begin
				if (p_q == LAST) begin
					state_d = S_DRG0;
				end else begin
					p_d = p_q + 1'b1;
					state_d = S_PICK;
				end
			end
			S_DRG0: begin
				op = cpf_pkg::OP_DRGX;
				state_d = S_DRG1;
			end
			S_DRG1: begin
				op = cpf_pkg::OP_DRGY;
				state_d = S_DRG2;
			end
			S_DRG2: begin
				op = cpf_pkg::OP_DRGE;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (!stat.out_full) begin
					op = cpf_pkg::OP_EMIT;
					if (b_q == LAST) begin
						state_d = S_IDLE;
					end else begin
						b_d = b_q + 1'b1;
						state_d = S_BEGIN;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			b_q <= '0;
			p_q <= '0;
		end else begin
			state_q <= state_d;
			b_q <= b_d;
			p_q <= p_d;
		end
	end

endmodule

`default_nettype wire

// File: hdl/cpf_dp.sv
// Datapath of the Coulomb pair force block: body store, serial multiplier,
// square root and divider, force accumulators and result register. Uses cpf_pkg.
`default_nettype none

module cpf_dp #(
	parameter int MAX_BODIES = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cpf_pkg::cmd_t    cmd,
	output cpf_pkg::stat_t   stat,
	input  cpf_pkg::item_t   item,
	input  logic             cfg_write,
	input  logic             cfg_index,
	input  logic [31:0]      cfg_data,
	output logic             result_valid,
	input  logic             result_ready,
	output cpf_pkg::result_t result
);

	localparam int IW = $clog2(MAX_BODIES);
	localparam logic [6:0] MUL_STEPS  = 7'd34;
	localparam logic [6:0] SQRT_STEPS = 7'd34;
	localparam logic [6:0] DIV_STEPS  = 7'd112;

	typedef enum logic [1:0] {U_IDLE, U_MUL, U_SQRT, U_DIV} unit_t;

	logic [31:0] gain_q, drag_q;
	logic [MAX_BODIES-1:0] valid_q;
	cpf_pkg::body_t mem [MAX_BODIES];
	cpf_pkg::body_t rec_q, self_q;
	logic [32:0] dx_q, dy_q;
	logic [31:0] qq_q;
	logic qneg_q;
	logic [62:0] kq_q;
	logic [65:0] r2_q;
	logic [99:0] den_q;
	logic [99:0] ma_q, prod_q;
	logic [33:0] mb_q;
	logic [67:0] rad_q;
	logic [36:0] rem_q;
	logic [33:0] root_q;
	logic [111:0] num_q;
	logic [100:0] drem_q;
	logic [48:0] quo_q;
	logic ovf_q;
	logic [63:0] dprod_q;
	logic [47:0] fx_q, fy_q;
	logic out_valid_q;
	cpf_pkg::result_t result_q;
	unit_t unit_q;
	logic [6:0] cnt_q;

	logic in_range;
	logic [IW-1:0] waddr, raddr;
	logic [32:0] adx, ady;
	logic [31:0] aqq, avx, avy;
	logic [47:0] qmag, dmag;
	logic [49:0] tx, ty, dxterm, dyterm;
	logic [36:0] sq_t, sq_trial;
	logic [100:0] dv_t;
	logic dv_ge;

	assign in_range = (32'(item.body_index) < 32'(MAX_BODIES));
	assign waddr = IW'(item.body_index);
	assign raddr = (cmd.op == cpf_pkg::OP_READ_PEER) ? cmd.peer_idx[IW-1:0]
		: cmd.self_idx[IW-1:0];

	assign adx = dx_q[32] ? (~dx_q + 33'd1) : dx_q;
	assign ady = dy_q[32] ? (~dy_q + 33'd1) : dy_q;
	assign aqq = qq_q[31] ? (~qq_q + 32'd1) : qq_q;
	assign avx = self_q.vel_x[31] ? (~self_q.vel_x + 32'd1) : self_q.vel_x;
	assign avy = self_q.vel_y[31] ? (~self_q.vel_y + 32'd1) : self_q.vel_y;

	// The quotient is clamped to two to the 47th before it takes its sign.
	assign qmag = (ovf_q || quo_q > 49'h0_8000_0000_0000) ? 48'h8000_0000_0000
		: quo_q[47:0];
	assign tx = (qneg_q ^ dx_q[32]) ? (~{2'b00, qmag} + 50'd1) : {2'b00, qmag};
	assign ty = (qneg_q ^ dy_q[32]) ? (~{2'b00, qmag} + 50'd1) : {2'b00, qmag};

	// Drag opposes the velocity.
	assign dmag = dprod_q[63:16];
	assign dxterm = self_q.vel_x[31] ? {2'b00, dmag} : (~{2'b00, dmag} + 50'd1);
	assign dyterm = self_q.vel_y[31] ? {2'b00, dmag} : (~{2'b00, dmag} + 50'd1);

	assign sq_t = {rem_q[34:0], rad_q[67:66]};
	assign sq_trial = {1'b0, root_q, 2'b01};
	assign dv_t = {drem_q[99:0], num_q[111]};
	assign dv_ge = (dv_t >= {1'b0, den_q});

	assign stat.busy = (unit_q != U_IDLE);
	assign stat.r2_zero = (prod_q == '0);
	assign stat.self_present = valid_q[cmd.self_idx[IW-1:0]];
	assign stat.peer_present = valid_q[cmd.peer_idx[IW-1:0]];
	assign stat.out_full = out_valid_q;

	assign result_valid = out_valid_q;
	assign result = result_q;

	always_ff @(posedge clk) begin
		if (cmd.op == cpf_pkg::OP_LOAD && in_range) begin
			mem[waddr] <= '{pos_x: item.position_x, pos_y: item.position_y,
				charge: item.charge, vel_x: item.speed_x, vel_y: item.speed_y};
		end
		rec_q <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			cpf_pkg::OP_BEGIN: begin
				fx_q <= '0;
				fy_q <= '0;
			end
			cpf_pkg::OP_SELF: begin
				self_q <= rec_q;
			end
			cpf_pkg::OP_PEER: begin
				dx_q <= {self_q.pos_x[31], self_q.pos_x} - {rec_q.pos_x[31], rec_q.pos_x};
				dy_q <= {self_q.pos_y[31], self_q.pos_y} - {rec_q.pos_y[31], rec_q.pos_y};
				qq_q <= $signed(self_q.charge) * $signed(rec_q.charge);
			end
			cpf_pkg::OP_SQX: begin
				ma_q <= 100'(adx);
				mb_q <= 34'(adx);
				prod_q <= '0;
			end
			cpf_pkg::OP_SQY: begin
				ma_q <= 100'(ady);
				mb_q <= 34'(ady);
			end
			cpf_pkg::OP_SQRT: begin
				r2_q <= prod_q[65:0];
				rad_q <= {2'b00, prod_q[65:0]};
				rem_q <= '0;
				root_q <= '0;
			end
			cpf_pkg::OP_DEN: begin
				ma_q <= 100'(r2_q);
				mb_q <= root_q;
				prod_q <= '0;
			end
			cpf_pkg::OP_KQ: begin
				den_q <= prod_q;
				kq_q <= gain_q * aqq[30:0];
				qneg_q <= qq_q[31];
			end
			cpf_pkg::OP_NUMX, cpf_pkg::OP_NUMY: begin
				ma_q <= 100'(kq_q);
				mb_q <= (cmd.op == cpf_pkg::OP_NUMX) ? 34'(adx) : 34'(ady);
				prod_q <= '0;
			end
			cpf_pkg::OP_DIVX, cpf_pkg::OP_DIVY: begin
				num_q <= {prod_q[95:0], 16'h0000};
				drem_q <= '0;
				quo_q <= '0;
				ovf_q <= 1'b0;
			end
			cpf_pkg::OP_ADDX: begin
				fx_q <= cpf_pkg::sat_add48(fx_q, tx);
			end
			cpf_pkg::OP_ADDY: begin
				fy_q <= cpf_pkg::sat_add48(fy_q, ty);
			end
			cpf_pkg::OP_DRGX: begin
				dprod_q <= drag_q * avx;
			end
			cpf_pkg::OP_DRGY: begin
				fx_q <= cpf_pkg::sat_add48(fx_q, dxterm);
				dprod_q <= drag_q * avy;
			end
			cpf_pkg::OP_DRGE: begin
				fy_q <= cpf_pkg::sat_add48(fy_q, dyterm);
			end
			cpf_pkg::OP_EMIT: begin
				result_q <= '{slot: 4'(cmd.self_idx),
					occupied: valid_q[cmd.self_idx[IW-1:0]],
					force_x: fx_q, force_y: fy_q,
					last: (cmd.self_idx == cpf_pkg::IDX_W'(MAX_BODIES - 1))};
			end
			default: begin
				// One step of whichever serial unit is running.
				case (unit_q)
					U_MUL: begin
						if (mb_q[0]) begin
							prod_q <= prod_q + ma_q;
						end
						ma_q <= {ma_q[98:0], 1'b0};
						mb_q <= {1'b0, mb_q[33:1]};
					end
					U_SQRT: begin
						if (sq_t >= sq_trial) begin
							rem_q <= sq_t - sq_trial;
							root_q <= {root_q[32:0], 1'b1};
						end else begin
							rem_q <= sq_t;
							root_q <= {root_q[32:0], 1'b0};
						end
						rad_q <= {rad_q[65:0], 2'b00};
					end
					U_DIV: begin
						drem_q <= dv_ge ? (dv_t - {1'b0, den_q}) : dv_t;
						quo_q <= {quo_q[47:0], dv_ge};
						ovf_q <= ovf_q | quo_q[48];
						num_q <= {num_q[110:0], 1'b0};
					end
					default: begin
					end
				endcase
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= 32'd65536;
			drag_q <= '0;
			valid_q <= '0;
			out_valid_q <= 1'b0;
			unit_q <= U_IDLE;
			cnt_q <= '0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					cpf_pkg::REG_COULOMB_GAIN: gain_q <= cfg_data;
					cpf_pkg::REG_DRAG_COEFF:   drag_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (cmd.op == cpf_pkg::OP_LOAD && in_range) begin
				valid_q[waddr] <= item.present;
			end
			if (cmd.op == cpf_pkg::OP_EMIT) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
			case (cmd.op)
				cpf_pkg::OP_SQX, cpf_pkg::OP_SQY, cpf_pkg::OP_DEN,
				cpf_pkg::OP_NUMX, cpf_pkg::OP_NUMY: begin
					unit_q <= U_MUL;
					cnt_q <= MUL_STEPS - 7'd1;
				end
				cpf_pkg::OP_SQRT: begin
					unit_q <= U_SQRT;
					cnt_q <= SQRT_STEPS - 7'd1;
				end
				cpf_pkg::OP_DIVX, cpf_pkg::OP_DIVY: begin
					unit_q <= U_DIV;
					cnt_q <= DIV_STEPS - 7'd1;
				end
				default: begin
					if (unit_q != U_IDLE) begin
						if (cnt_q == '0) begin
							unit_q <= U_IDLE;
						end else begin
							cnt_q <= cnt_q - 7'd1;
						end
					end
				end
			endcase
		end
	end

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == cpf_pkg::OP_EMIT) |-> !out_valid_q)
		else $error("result register overwritten");

	a_unit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == cpf_pkg::OP_SQX || cmd.op == cpf_pkg::OP_SQY ||
		 cmd.op == cpf_pkg::OP_SQRT || cmd.op == cpf_pkg::OP_DEN ||
		 cmd.op == cpf_pkg::OP_NUMX || cmd.op == cpf_pkg::OP_NUMY ||
		 cmd.op == cpf_pkg::OP_DIVX || cmd.op == cpf_pkg::OP_DIVY) |-> (unit_q == U_IDLE))
		else $error("serial unit started while busy");

	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == cpf_pkg::OP_DIVX || cmd.op == cpf_pkg::OP_DIVY) |-> (den_q != '0))
		else $error("division by zero distance");

endmodule

`default_nettype wire

// File: hdl/coulomb_pairwise_force_with_drag.sv
// Top level of the direct-sum Coulomb force block with velocity drag.
// Instantiates cpf_ctrl and cpf_dp; types come from cpf_pkg.
`default_nettype none

// The block holds MAX_BODIES body slots. A load word is taken while the block is
// idle and writes one slot (a slot number at or beyond MAX_BODIES is ignored). A
// compute word produces one result word per slot, in slot order, the final one
// marked last. Each slot's force is built up alone: for every other present
// body, in ascending slot order, the pair term is worked out with a shared
// serial multiplier (five products per pair), a serial square root and a serial
// divider (one division per axis); a pair whose two bodies sit at the same place
// is dropped once its squared distance is known. A present slot then gets its
// drag terms and is emitted; an empty slot is emitted with no further work. The
// result sits in an output register, so the next slot's work carries on while a
// result waits to be taken; a new word is accepted once the last result has been
// placed in that register. Configuration writes take effect at once and must
// only be made while the block is idle.
module coulomb_pairwise_force_with_drag #(
	parameter int MAX_BODIES = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  cpf_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_ready,
	output cpf_pkg::result_t result,
	input  logic             cfg_write,
	input  logic             cfg_index,
	input  logic [31:0]      cfg_data
);

	// Command and status between the sequencer and the datapath.
	cpf_pkg::cmd_t  cmd;
	cpf_pkg::stat_t stat;

	cpf_ctrl #(
		.MAX_BODIES(MAX_BODIES)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_action(item.action),
		.item_ready (item_ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	cpf_dp #(
		.MAX_BODIES(MAX_BODIES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.item        (item),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

endmodule

`default_nettype wire
